/* hw/rtl/sem_pkg.sv */
// shared types, constants and helper functions for the sobel edge magnitude block
// no dependencies

package sem_pkg;

	localparam int PIXEL_BITS = 8;
	localparam int MAX_WIDTH  = 1024;
	localparam int IN_W       = 8;
	localparam int CFG_W      = 11;
	localparam int EDGE_W     = 11;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int CMP_W      = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
	localparam int MIN_WIDTH  = 3;
	localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(640);

	localparam int GRAD_W = PIXEL_BITS + 3;
	localparam int SUM_W  = 2 * (PIXEL_BITS + 2) + 1;
	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int SQW    = 2 * ROOT_W;
	localparam int ITER_W = $clog2(ROOT_W + 1);
	localparam int CH_N   = 3;

	typedef logic [PIXEL_BITS-1:0] pix_t;
	typedef pix_t [CH_N-1:0] rgb_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic signed [GRAD_W-1:0] grad_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [ROOT_W-1:0] root_t;
	typedef logic [EDGE_W-1:0] edge_t;

	typedef struct packed {
		rgb_t two_back;
		rgb_t one_back;
	} lines_t;

	typedef struct packed {
		rgb_t a0;
		rgb_t a1;
		rgb_t a2;
		rgb_t b0;
		rgb_t b2;
		rgb_t c0;
		rgb_t c1;
		rgb_t c2;
	} nbhd_t;

	function automatic pix_t to_pix(input logic [IN_W-1:0] v);
		logic [PIXEL_BITS+IN_W-1:0] t;
		t = {{PIXEL_BITS{1'b0}}, v};
		return t[PIXEL_BITS-1:0];
	endfunction

	function automatic edge_t to_edge(input root_t v);
		logic [ROOT_W+EDGE_W-1:0] t;
		t = {{EDGE_W{1'b0}}, v};
		return t[EDGE_W-1:0];
	endfunction

endpackage

/* hw/rtl/sem_line_store.sv */
// line store memory: rows one and two back, packed in one word per column
// depends on sem_pkg

module sem_line_store
	import sem_pkg::*;
(
	input  logic   clk,
	input  logic   rd_en,
	input  addr_t  rd_addr,
	output lines_t rd_data,
	input  logic   wr_en,
	input  addr_t  wr_addr,
	input  lines_t wr_data
);

	lines_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/sem_gradient.sv */
// sobel gradients per channel, then squared sum, two register stages
// depends on sem_pkg

module sem_gradient
	import sem_pkg::*;
(
	input  logic             clk,
	input  logic             load_grad,
	input  logic             load_sq,
	input  nbhd_t            nbhd,
	output sum_t [CH_N-1:0]  sum_s2
);

	grad_t gx_s1 [CH_N];
	grad_t gy_s1 [CH_N];
	grad_t gx_c [CH_N];
	grad_t gy_c [CH_N];
	sum_t  sum_c [CH_N];

	function automatic grad_t ext(input pix_t p);
		return $signed({3'b000, p});
	endfunction

	always_comb begin
		grad_t a0, a1, a2, b0, b2, c0, c1, c2;
		logic signed [2*GRAD_W-1:0] sqx, sqy;
		for (int ch = 0; ch < CH_N; ch++) begin
			a0 = ext(nbhd.a0[ch]);
			a1 = ext(nbhd.a1[ch]);
			a2 = ext(nbhd.a2[ch]);
			b0 = ext(nbhd.b0[ch]);
			b2 = ext(nbhd.b2[ch]);
			c0 = ext(nbhd.c0[ch]);
			c1 = ext(nbhd.c1[ch]);
			c2 = ext(nbhd.c2[ch]);
			gx_c[ch] = (a2 - a0) + (b2 - b0) + (b2 - b0) + (c2 - c0);
			gy_c[ch] = (c0 + c1 + c1 + c2) - (a0 + a1 + a1 + a2);
			sqx = gx_s1[ch] * gx_s1[ch];
			sqy = gy_s1[ch] * gy_s1[ch];
			sum_c[ch] = {1'b0, sqx[SUM_W-2:0]} + {1'b0, sqy[SUM_W-2:0]};
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < CH_N; ch++) begin
			if (load_grad) begin
				gx_s1[ch] <= gx_c[ch];
				gy_s1[ch] <= gy_c[ch];
			end
			if (load_sq) begin
				sum_s2[ch] <= sum_c[ch];
			end
		end
	end

endmodule

/* hw/rtl/sem_isqrt.sv */
// iterative integer square root, one result bit per step
// depends on sem_pkg

module sem_isqrt
	import sem_pkg::*;
(
	input  logic  clk,
	input  logic  load,
	input  logic  step,
	input  sum_t  value,
	output root_t root
);

	logic [SQW-1:0] rem_q;
	logic [SQW-1:0] root_q;
	logic [SQW-1:0] bit_q;
	logic [SQW-1:0] trial;

	assign trial = root_q + bit_q;
	assign root  = root_q[ROOT_W-1:0];

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= SQW'(value);
			root_q <= '0;
			bit_q  <= SQW'(1) << (SQW - 2);
		end else if (step) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

/* hw/rtl/sobel_edge_magnitude_rgb.sv */
// sobel edge magnitude top level: counters, window, sequencer, output register
// depends on sem_pkg, sem_line_store, sem_gradient, sem_isqrt
//
// usage:
//   input channel (in_valid / in_stall): one rgb pixel per request in raster
//   order, frame_start on the first pixel of a frame restarts the counters.
//   output channel (out_valid / out_stall): one request per full 3x3 window,
//   three 11-bit magnitudes plus row_last on the last result of a row.
//   cfg_write / cfg_data write image_width; write it only while idle.
// flow:
//   a pixel without a result goes through the line store read, then window
//   update and write back. a pixel with a result goes through read, gradient,
//   square, root load, 11 square root steps and hand-off; out_valid rises at
//   the hand-off once the output register is free.
//   the next pixel is taken while a result waits in the output register; a
//   second result waits inside until the receiver drops out_stall.
// reset: counters clear, width returns to 640, output empty. line store
//   contents are undefined until written and need no clearing pass.

module sobel_edge_magnitude_rgb
	import sem_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [IN_W-1:0]   red,
	input  logic [IN_W-1:0]   green,
	input  logic [IN_W-1:0]   blue,
	input  logic              frame_start,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [EDGE_W-1:0] red_edge,
	output logic [EDGE_W-1:0] green_edge,
	output logic [EDGE_W-1:0] blue_edge,
	output logic              row_last
);

	typedef enum logic [2:0] {
		IDLE,
		READ,
		SQUARE,
		LOAD,
		ROOT,
		DONE
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  width_q;
	addr_t             col_q;
	logic [1:0]        rows_q;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;

	addr_t             x_q;
	rgb_t              cur_q;
	logic              last_q;
	logic              prod_q;
	rgb_t              win_q [6];
	edge_t [CH_N-1:0]  edge_q;
	logic              row_last_q;

	logic              accept;
	addr_t             x_in;
	logic [1:0]        rows_in;
	logic [CMP_W-1:0]  w_eff;
	logic [CMP_W-1:0]  w_raw;
	logic              last_in;
	logic              prod_in;
	rgb_t              pix_in;

	lines_t            rd_data;
	lines_t            wr_data;
	nbhd_t             nbhd;
	sum_t [CH_N-1:0]   sums;
	root_t             roots [CH_N];
	logic              out_free;

	assign in_stall  = (state_q != IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign red_edge   = edge_q[0];
	assign green_edge = edge_q[1];
	assign blue_edge  = edge_q[2];
	assign row_last   = row_last_q;

	assign pix_in[0] = to_pix(red);
	assign pix_in[1] = to_pix(green);
	assign pix_in[2] = to_pix(blue);

	always_comb begin
		w_raw = CMP_W'(width_q);
		if (w_raw < CMP_W'(MIN_WIDTH)) begin
			w_eff = CMP_W'(MIN_WIDTH);
		end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		x_in    = frame_start ? '0 : col_q;
		rows_in = frame_start ? 2'd0 : rows_q;
		last_in = (CMP_W'(x_in) + CMP_W'(1)) >= w_eff;
		prod_in = (rows_in == 2'd2) && (x_in >= ADDR_W'(2));
	end

	assign wr_data.two_back = rd_data.one_back;
	assign wr_data.one_back = cur_q;

	assign nbhd.a0 = win_q[0];
	assign nbhd.a1 = win_q[3];
	assign nbhd.a2 = rd_data.two_back;
	assign nbhd.b0 = win_q[1];
	assign nbhd.b2 = rd_data.one_back;
	assign nbhd.c0 = win_q[2];
	assign nbhd.c1 = win_q[5];
	assign nbhd.c2 = cur_q;

	sem_line_store u_lines (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (x_in),
		.rd_data (rd_data),
		.wr_en   (state_q == READ),
		.wr_addr (x_q),
		.wr_data (wr_data)
	);

	sem_gradient u_grad (
		.clk       (clk),
		.load_grad (state_q == READ),
		.load_sq   (state_q == SQUARE),
		.nbhd      (nbhd),
		.sum_s2    (sums)
	);

	for (genvar ch = 0; ch < CH_N; ch++) begin : g_root
		sem_isqrt u_isqrt (
			.clk   (clk),
			.load  (state_q == LOAD),
			.step  (state_q == ROOT),
			.value (sums[ch]),
			.root  (roots[ch])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			width_q     <= WIDTH_RESET;
			col_q       <= '0;
			rows_q      <= 2'd0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				width_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						col_q <= last_in ? '0 : x_in + ADDR_W'(1);
						if (last_in && rows_in != 2'd2) begin
							rows_q <= rows_in + 2'd1;
						end else begin
							rows_q <= rows_in;
						end
						state_q <= READ;
					end
				end
				READ: begin
					state_q <= prod_q ? SQUARE : IDLE;
				end
				SQUARE: begin
					state_q <= LOAD;
				end
				LOAD: begin
					iter_q  <= ITER_W'(ROOT_W - 1);
					state_q <= ROOT;
				end
				ROOT: begin
					if (iter_q == '0) begin
						state_q <= DONE;
					end else begin
						iter_q <= iter_q - ITER_W'(1);
					end
				end
				DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= x_in;
			cur_q  <= pix_in;
			last_q <= last_in;
			prod_q <= prod_in;
		end
		if (state_q == READ) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= rd_data.two_back;
			win_q[4] <= rd_data.one_back;
			win_q[5] <= cur_q;
		end
		if (state_q == DONE && out_free) begin
			for (int ch = 0; ch < CH_N; ch++) begin
				edge_q[ch] <= to_edge(roots[ch]);
			end
			row_last_q <= last_q;
		end
	end

endmodule
